@@ hw/rtl/ss16_pkg.sv @@
// ----------------------------------------------------------------------------
// ss16_pkg
// Shared widths, codes and payload types of the 16-step sequencer.
// ----------------------------------------------------------------------------
package ss16_pkg;

    localparam int MAX_STEPS     = 16;
    localparam int STEP_BITS     = 4;
    localparam int ROW_COUNT     = 3;
    localparam int ROW_BITS      = 2;
    localparam int VALUE_BITS    = 12;
    localparam int ADDR_BITS     = 6;
    localparam int PHASE_BITS    = 32;
    localparam int INC_BITS      = 31;
    localparam int COUNT_BITS    = 5;
    localparam int PULSE_BITS    = 16;
    localparam int MODE_BITS     = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int IN_BITS       = 80;
    localparam int IN_USED_BITS  = 76;
    localparam int OUT_BITS      = 64;
    localparam int OUT_USED_BITS = 59;

    localparam logic [MODE_BITS-1:0] GATE_MODE_TRIGGER   = 2'd0;
    localparam logic [MODE_BITS-1:0] GATE_MODE_RETRIGGER = 2'd1;
    localparam logic [MODE_BITS-1:0] GATE_MODE_RESET     = GATE_MODE_TRIGGER;

    localparam logic [PULSE_BITS-1:0] PULSE_TICKS_RESET = 16'd44;

    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic CFG_GATE_MODE   = 1'b0;
    localparam logic CFG_PULSE_TICKS = 1'b1;

    // declared from the highest field down, so the last field, run_button, sits in bit 0
    typedef struct packed {
        logic [VALUE_BITS-1:0] table_value;
        logic [ADDR_BITS-1:0]  table_address;
        logic [MAX_STEPS-1:0]  gate_buttons;
        logic [COUNT_BITS-1:0] step_count;
        logic [INC_BITS-1:0]   phase_increment;
        logic                  reset_level;
        logic                  ext_clock_level;
        logic                  ext_clock_connected;
        logic                  stop_level;
        logic                  start_level;
        logic                  run_button;
    } tick_in_t;

    typedef struct packed {
        logic                 running;
        logic                 clock_tick;
        logic                 gate_qual;
        logic [STEP_BITS-1:0] step;
    } ctrl_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] row3_value;
        logic [VALUE_BITS-1:0] row2_value;
        logic [VALUE_BITS-1:0] row1_value;
        logic [STEP_BITS-1:0]  current_step;
        logic                  is_running;
        logic                  clock_tick;
        logic                  gates_active;
        logic [MAX_STEPS-1:0]  gate_vector;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        logic       pop;
    } buf_stat_t;

endpackage

@@ hw/rtl/ss16_ctrl.sv @@
// ----------------------------------------------------------------------------
// ss16_ctrl
// Run state, phase clock, external clock, step counter and gate pulse timer.
// ----------------------------------------------------------------------------
module ss16_ctrl
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [ss16_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                              tick_fire,
    input  ss16_pkg::tick_in_t                in_item,
    output ss16_pkg::ctrl_t                   ctrl
);

    logic [ss16_pkg::MODE_BITS-1:0]  gate_mode_reg;
    logic [ss16_pkg::PULSE_BITS-1:0] pulse_ticks_reg;
    logic                            run_reg, run_next;
    logic [ss16_pkg::PHASE_BITS-1:0] acc_reg, acc_next;
    logic [ss16_pkg::STEP_BITS-1:0]  step_reg, step_next;
    logic [ss16_pkg::PULSE_BITS-1:0] pulse_cnt_reg, pulse_cnt_next;
    logic                            prev_run_reg, prev_ext_reg, prev_rst_reg;
    logic                            prev_ext_next;

    logic [ss16_pkg::PHASE_BITS:0]   sum;
    logic                            ext_rise, rst_rise, adv_clk, advance;
    logic [ss16_pkg::COUNT_BITS-1:0] count, step_inc;
    logic [ss16_pkg::PULSE_BITS-1:0] pulse_load;
    logic                            pulse;

    always_comb
    begin
        run_next = run_reg ^ (in_item.run_button & ~prev_run_reg);
        if (in_item.start_level)
        begin
            run_next = 1'b1;
        end
        if (in_item.stop_level)
        begin
            run_next = 1'b0;
        end

        sum      = {1'b0, acc_reg} + {2'b00, in_item.phase_increment};
        ext_rise = in_item.ext_clock_level & ~prev_ext_reg;
        rst_rise = in_item.reset_level & ~prev_rst_reg;

        adv_clk       = 1'b0;
        acc_next      = acc_reg;
        prev_ext_next = prev_ext_reg;
        if (run_next)
        begin
            if (in_item.ext_clock_connected)
            begin
                prev_ext_next = in_item.ext_clock_level;
                if (ext_rise)
                begin
                    acc_next = '0;
                    adv_clk  = 1'b1;
                end
            end
            else
            begin
                acc_next = sum[ss16_pkg::PHASE_BITS-1:0];
                adv_clk  = sum[ss16_pkg::PHASE_BITS];
            end
        end
        if (rst_rise)
        begin
            acc_next = '0;
        end

        if (in_item.step_count == '0)
        begin
            count = ss16_pkg::COUNT_BITS'(1);
        end
        else if (in_item.step_count > ss16_pkg::COUNT_BITS'(ss16_pkg::MAX_STEPS))
        begin
            count = ss16_pkg::COUNT_BITS'(ss16_pkg::MAX_STEPS);
        end
        else
        begin
            count = in_item.step_count;
        end

        step_inc = {1'b0, step_reg} + ss16_pkg::COUNT_BITS'(1);
        advance  = adv_clk | rst_rise;
        if (rst_rise)
        begin
            step_next = '0;
        end
        else if (adv_clk)
        begin
            step_next = (step_inc >= count) ? '0 : step_inc[ss16_pkg::STEP_BITS-1:0];
        end
        else
        begin
            step_next = step_reg;
        end

        pulse_load     = advance ? pulse_ticks_reg : pulse_cnt_reg;
        pulse          = pulse_load != '0;
        pulse_cnt_next = pulse ? pulse_load - ss16_pkg::PULSE_BITS'(1) : pulse_load;

        ctrl.running    = run_next;
        ctrl.clock_tick = adv_clk;
        ctrl.step       = step_next;
        case (gate_mode_reg)
            ss16_pkg::GATE_MODE_TRIGGER:   ctrl.gate_qual = pulse;
            ss16_pkg::GATE_MODE_RETRIGGER: ctrl.gate_qual = ~pulse;
            default:                       ctrl.gate_qual = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_mode_reg   <= ss16_pkg::GATE_MODE_RESET;
            pulse_ticks_reg <= ss16_pkg::PULSE_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ss16_pkg::CFG_GATE_MODE:
                begin
                    gate_mode_reg <= cfg_data[ss16_pkg::MODE_BITS-1:0];
                end
                ss16_pkg::CFG_PULSE_TICKS:
                begin
                    pulse_ticks_reg <= cfg_data[ss16_pkg::PULSE_BITS-1:0];
                end
                default:
                begin
                    gate_mode_reg <= gate_mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b1;
            acc_reg       <= '0;
            step_reg      <= '0;
            pulse_cnt_reg <= '0;
            prev_run_reg  <= 1'b0;
            prev_ext_reg  <= 1'b0;
            prev_rst_reg  <= 1'b0;
        end
        else if (tick_fire)
        begin
            run_reg       <= run_next;
            acc_reg       <= acc_next;
            step_reg      <= step_next;
            pulse_cnt_reg <= pulse_cnt_next;
            prev_run_reg  <= in_item.run_button;
            prev_ext_reg  <= prev_ext_next;
            prev_rst_reg  <= in_item.reset_level;
        end
    end

endmodule

@@ hw/rtl/ss16_gate_lane.sv @@
// ----------------------------------------------------------------------------
// ss16_gate_lane
// One step's gate: button edge toggle of the enable and the qualified gate.
// ----------------------------------------------------------------------------
module ss16_gate_lane
(
    input  logic clk,
    input  logic rst_n,
    input  logic tick_fire,
    input  logic button,
    input  logic sel,
    input  logic running,
    input  logic qual,
    output logic gate
);

    logic en_reg, en_next;
    logic prev_reg;

    assign en_next = en_reg ^ (button & ~prev_reg);
    assign gate    = running & en_next & sel & qual;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg   <= 1'b0;
            prev_reg <= 1'b0;
        end
        else if (tick_fire)
        begin
            en_reg   <= en_next;
            prev_reg <= button;
        end
    end

endmodule

@@ hw/rtl/ss16_row_lane.sv @@
// ----------------------------------------------------------------------------
// ss16_row_lane
// One row of step values: write port, registered read, per-entry valid bits.
// ----------------------------------------------------------------------------
module ss16_row_lane
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             we,
    input  logic [ss16_pkg::STEP_BITS-1:0]   wr_pos,
    input  logic [ss16_pkg::VALUE_BITS-1:0]  wr_value,
    input  logic                             re,
    input  logic [ss16_pkg::STEP_BITS-1:0]   rd_pos,
    output logic [ss16_pkg::VALUE_BITS-1:0]  rd_value
);

    logic [ss16_pkg::VALUE_BITS-1:0] mem [ss16_pkg::MAX_STEPS];
    logic [ss16_pkg::MAX_STEPS-1:0]  valid_reg;
    logic [ss16_pkg::VALUE_BITS-1:0] mem_q_reg;
    logic                            vld_q_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_pos] <= wr_value;
        end
        if (re)
        begin
            mem_q_reg <= mem[rd_pos];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[wr_pos] <= 1'b1;
            end
            if (re)
            begin
                vld_q_reg <= valid_reg[rd_pos];
            end
        end
    end

    // never-written entries read as zero
    assign rd_value = vld_q_reg ? mem_q_reg : '0;

endmodule

@@ hw/rtl/ss16_out_buf.sv @@
// ----------------------------------------------------------------------------
// ss16_out_buf
// Two-entry result buffer in front of the output stream.
// ----------------------------------------------------------------------------
module ss16_out_buf
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  ss16_pkg::result_t               push_data,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [ss16_pkg::OUT_BITS-1:0]   m_tdata,
    output ss16_pkg::buf_stat_t             stat
);

    ss16_pkg::result_t ent_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        cnt_reg, cnt_next;
    logic              pop;

    assign m_tvalid = cnt_reg != 2'd0;
    assign m_tdata  = {{(ss16_pkg::OUT_BITS - ss16_pkg::OUT_USED_BITS){1'b0}},
                       ent_reg[rd_ptr_reg]};
    assign pop      = m_tvalid & m_tready;
    assign stat     = '{count: cnt_reg, pop: pop};

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

endmodule

@@ hw/rtl/step_sequencer_16.sv @@
// ----------------------------------------------------------------------------
// step_sequencer_16
// Sixteen-step sequencer: run control, clocking, gate lanes and three rows.
// ----------------------------------------------------------------------------
// Takes one transfer per clock when the output side keeps up. A tick transfer
// yields one result: the cycle of acceptance updates the step state, the
// sixteen gate lanes and the registered read of the row memories, then the
// lane gates are merged and the result goes through a two-entry
// output buffer. A table write transfer yields no result. The output buffer
// lets the input side keep going while one result waits. Reset clears the
// per-entry valid bits of the row memories at once, so no clearing pass runs.
module step_sequencer_16
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic                                   cfg_index,
    input  logic [ss16_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // run_button, start_level, stop_level, ext_clock_connected,
    // ext_clock_level, reset_level, phase_increment, step_count,
    // gate_buttons, table_address, table_value
    input  logic [ss16_pkg::IN_BITS-1:0]           s_tdata,
    // action
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // gate_vector, gates_active, clock_tick, is_running, current_step,
    // row1_value, row2_value, row3_value
    output logic [ss16_pkg::OUT_BITS-1:0]          m_tdata
);

    ss16_pkg::tick_in_t  in_item;
    ss16_pkg::ctrl_t     ctrl;
    ss16_pkg::result_t   result;
    ss16_pkg::buf_stat_t stat;

    logic accept, tick_fire, wr_fire;
    logic [ss16_pkg::ROW_BITS-1:0]   wr_row;
    logic [ss16_pkg::STEP_BITS-1:0]  wr_pos;
    logic [ss16_pkg::MAX_STEPS-1:0]  lane_gate;
    logic [ss16_pkg::VALUE_BITS-1:0] row_value [ss16_pkg::ROW_COUNT];

    logic                           a_valid_reg;
    logic [ss16_pkg::MAX_STEPS-1:0] a_gates_reg;
    ss16_pkg::ctrl_t                a_ctrl_reg;
    logic [1:0]                     occupancy;

    assign in_item   = ss16_pkg::tick_in_t'(s_tdata[ss16_pkg::IN_USED_BITS-1:0]);
    assign accept    = s_tvalid & s_tready;
    assign tick_fire = accept & (s_tuser == ss16_pkg::ACT_TICK);
    assign wr_fire   = accept & (s_tuser == ss16_pkg::ACT_WRITE);
    assign wr_row    = in_item.table_address[ss16_pkg::ADDR_BITS-1:ss16_pkg::STEP_BITS];
    assign wr_pos    = in_item.table_address[ss16_pkg::STEP_BITS-1:0];

    assign occupancy = {1'b0, a_valid_reg} + stat.count;
    assign s_tready  = (occupancy < 2'd2) | stat.pop;

    ss16_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick_fire (tick_fire),
        .in_item   (in_item),
        .ctrl      (ctrl)
    );

    for (genvar g = 0; g < ss16_pkg::MAX_STEPS; g++)
    begin : g_gate
        ss16_gate_lane u_lane
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .tick_fire (tick_fire),
            .button    (in_item.gate_buttons[g]),
            .sel       (ctrl.step == ss16_pkg::STEP_BITS'(g)),
            .running   (ctrl.running),
            .qual      (ctrl.gate_qual),
            .gate      (lane_gate[g])
        );
    end

    for (genvar r = 0; r < ss16_pkg::ROW_COUNT; r++)
    begin : g_row
        ss16_row_lane u_row
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .we       (wr_fire && (wr_row == ss16_pkg::ROW_BITS'(r))),
            .wr_pos   (wr_pos),
            .wr_value (in_item.table_value),
            .re       (tick_fire),
            .rd_pos   (ctrl.step),
            .rd_value (row_value[r])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= tick_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            a_gates_reg <= lane_gate;
            a_ctrl_reg  <= ctrl;
        end
    end

    // merge of the lane results
    always_comb
    begin
        result.gate_vector  = a_gates_reg;
        result.gates_active = |a_gates_reg;
        result.clock_tick   = a_ctrl_reg.clock_tick;
        result.is_running   = a_ctrl_reg.running;
        result.current_step = a_ctrl_reg.step;
        result.row1_value   = row_value[0];
        result.row2_value   = row_value[1];
        result.row3_value   = row_value[2];
    end

    ss16_out_buf u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (a_valid_reg),
        .push_data (result),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .stat      (stat)
    );

endmodule

@@ hw/rtl/ss16_checker.sv @@
// ----------------------------------------------------------------------------
// ss16_checker
// Port-level checks of the sequencer result stream.
// ----------------------------------------------------------------------------
module ss16_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ss16_pkg::OUT_BITS-1:0] m_tdata
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result valid dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    a_gate_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0(m_tdata[15:0]))
        else $error("more than one gate set");

    a_gate_at_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:0] == (16'(m_tdata[16]) << m_tdata[22:19]))
        else $error("gate vector does not match active gate at current step");

    a_gate_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[16] |-> m_tdata[18])
        else $error("gate active while stopped");

endmodule

bind step_sequencer_16 ss16_checker u_ss16_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
